// ===== sv/pit_pkg.sv =====
// Shared types and constants for the programmable interval timer.
`timescale 1ns / 1ps
package pit_pkg;

    // Item kinds.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [1:0] PORT_CTRL  = 2'd3;
    localparam logic [1:0] CH_READBACK = 2'd3;
    localparam logic [1:0] ACC_LATCH  = 2'd0;

    // Byte-phase codes for reads, writes and count latches.
    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_LSB  = 3'd1;
    localparam logic [2:0] PH_MSB  = 3'd2;
    localparam logic [2:0] PH_WLO  = 3'd3;
    localparam logic [2:0] PH_WHI  = 3'd4;

    // Counting modes.
    localparam logic [2:0] MODE_0 = 3'd0;
    localparam logic [2:0] MODE_1 = 3'd1;
    localparam logic [2:0] MODE_2 = 3'd2;
    localparam logic [2:0] MODE_3 = 3'd3;
    localparam logic [2:0] MODE_4 = 3'd4;
    localparam logic [2:0] MODE_5 = 3'd5;

    localparam logic [16:0] FULL_RELOAD = 17'h10000;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] port;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq0_level;
        logic       irq0_period_done;
    } result_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic execute;
        logic deliver;
    } pit_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic item_valid;
        logic out_free;
    } pit_status_t;

endpackage

// ===== sv/programmable_interval_timer.sv =====
// Top level of the programmable interval timer: item capture, channels and result register.
`timescale 1ns / 1ps
// Three-channel interval timer behind a byte-wide register interface. Each
// input beat is a timer tick, a port read or a port write; each one yields
// exactly one result beat carrying the read byte, the channel 0 output level
// after the beat and a flag that marks a tick completing a channel 0 period.
// The controller runs three states per item (capture, execute, result): the
// item is accepted in the idle state, executed in the next cycle, and its
// result is loaded into the output register from the result state once the
// output register is free. A new item is accepted only after the last one
// has left the result state; a stalled output keeps the controller in
// its result state and holds off the input until the output register frees.
// A new item is accepted while an earlier result waits to be taken.
// Each channel keeps its elapsed count modulo the reload value as a running
// residue updated on every tick, so no divider is needed; there is no
// clearing pass after reset. BCD is recorded in the status byte only.
module programmable_interval_timer
    import pit_pkg::*;
#(
    parameter int NUM_CHANNELS  = 3,
    parameter int ELAPSED_WIDTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    pit_cmd_t    cmd;
    pit_status_t status;
    logic        busy;

    item_t       item_reg;
    logic [7:0]  rd_reg, rd_next;
    logic        valid_reg;
    result_t     result_reg;

    logic [NUM_CHANNELS-1:0] ch_level;
    logic [NUM_CHANNELS-1:0] ch_hit;
    logic [7:0]              ch_rd [NUM_CHANNELS];

    assign status.item_valid = item_valid;
    assign status.out_free   = !valid_reg || !result_stall;
    assign item_stall        = busy;

    pit_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_chan
        pit_chan #(
            .ELAPSED_WIDTH (ELAPSED_WIDTH),
            .CH_IDX        (g)
        ) u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .execute    (cmd.execute),
            .item       (item_reg),
            .rd_byte    (ch_rd[g]),
            .level      (ch_level[g]),
            .period_hit (ch_hit[g])
        );
    end

    // Channels drive zero unless their own read is in progress.
    always_comb
    begin
        rd_next = 8'd0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            rd_next = rd_next | ch_rd[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.execute)
        begin
            rd_reg <= rd_next;
        end
        if (cmd.deliver)
        begin
            result_reg.read_data        <= rd_reg;
            result_reg.irq0_level       <= ch_level[0];
            result_reg.irq0_period_done <= (item_reg.func == FUNC_TICK) && ch_hit[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.deliver)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // An accepted beat keeps the input side stalled while it executes.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input accepted while an item is in flight");

    // A period flag comes only with a tick, which never returns read data.
    a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.irq0_period_done) |-> (result.read_data == 8'd0))
        else $error("period flag raised on a non-tick result");

    // A result is never overwritten while it is held by the receiver.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !cmd.deliver)
        else $error("result register overwritten while stalled");
`endif

endmodule

// ===== sv/pit_ctrl.sv =====
// Sequencing state machine of the programmable interval timer.
`timescale 1ns / 1ps
module pit_ctrl
    import pit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pit_status_t status,
    output pit_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (status.item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/pit_chan.sv =====
// Datapath of one timer channel: counter state, running residue, latches and byte phases.
`timescale 1ns / 1ps
module pit_chan
    import pit_pkg::*;
#(
    parameter int ELAPSED_WIDTH = 32,
    parameter int CH_IDX        = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       execute,
    input  item_t      item,
    output logic [7:0] rd_byte,
    output logic       level,
    output logic       period_hit
);

    logic [16:0]              reload_reg, reload_next;
    logic [ELAPSED_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [15:0]              resid_reg, resid_next;
    logic [15:0]              latched_reg, latched_next;
    logic [2:0]               clp_reg, clp_next;
    logic                     slf_reg, slf_next;
    logic [7:0]               status_reg, status_next;
    logic [2:0]               rph_reg, rph_next;
    logic [2:0]               wph_reg, wph_next;
    logic [7:0]               low_reg, low_next;
    logic [1:0]               acc_reg, acc_next;
    logic [2:0]               mode_reg, mode_next;
    logic                     bcd_reg, bcd_next;

    logic [15:0]              live;
    logic [16:0]              twice;
    logic [16:0]              twice_mod;
    logic [17:0]              half_up;
    logic [16:0]              resid_inc;
    logic [ELAPSED_WIDTH-1:0] elapsed_inc;
    logic [ELAPSED_WIDTH-1:0] reload_ext;
    logic [1:0]               cw_ch;
    logic [1:0]               cw_acc;
    logic                     sel;
    logic                     op_tick, op_read, op_dwrite, op_ctrl;
    logic                     readback, latch_req, status_req, program_req;
    logic                     load_req;
    logic [15:0]              load_val;

    assign reload_ext = ELAPSED_WIDTH'(reload_reg);
    assign twice      = {resid_reg, 1'b0};
    assign twice_mod  = (twice >= reload_reg) ? (twice - reload_reg) : twice;
    assign half_up    = (18'(reload_reg) + 18'd1) >> 1;

    always_comb
    begin
        case (mode_reg)
            MODE_0, MODE_1, MODE_4, MODE_5:
                live = reload_reg[15:0] - elapsed_reg[15:0];
            MODE_3:
                live = reload_reg[15:0] - twice_mod[15:0];
            default:
                live = reload_reg[15:0] - resid_reg;
        endcase
        case (mode_reg)
            MODE_2:         level = (resid_reg == 16'd0) && (elapsed_reg != '0);
            MODE_3:         level = 18'(resid_reg) < half_up;
            MODE_4, MODE_5: level = (elapsed_reg == reload_ext);
            default:        level = (elapsed_reg >= reload_ext);
        endcase
    end

    assign period_hit = (resid_reg == 16'd0) && (elapsed_reg != '0);

    assign sel       = (item.port == 2'(CH_IDX));
    assign op_tick   = execute && (item.func == FUNC_TICK);
    assign op_read   = execute && (item.func == FUNC_READ) && sel;
    assign op_dwrite = execute && (item.func == FUNC_WRITE) && sel;
    assign op_ctrl   = execute && (item.func == FUNC_WRITE) && (item.port == PORT_CTRL);
    assign cw_ch     = item.write_data[7:6];
    assign cw_acc    = item.write_data[5:4];
    assign readback  = op_ctrl && (cw_ch == CH_READBACK) && item.write_data[1 + CH_IDX];
    assign latch_req = (readback && !item.write_data[5])
                     || (op_ctrl && (cw_ch == 2'(CH_IDX)) && (cw_acc == ACC_LATCH));
    assign status_req  = readback && !item.write_data[4] && !slf_reg;
    assign program_req = op_ctrl && (cw_ch == 2'(CH_IDX)) && (cw_acc != ACC_LATCH);

    assign elapsed_inc = elapsed_reg + ELAPSED_WIDTH'(1);
    assign resid_inc   = 17'(resid_reg) + 17'd1;

    always_comb
    begin
        reload_next  = reload_reg;
        elapsed_next = elapsed_reg;
        resid_next   = resid_reg;
        latched_next = latched_reg;
        clp_next     = clp_reg;
        slf_next     = slf_reg;
        status_next  = status_reg;
        rph_next     = rph_reg;
        wph_next     = wph_reg;
        low_next     = low_reg;
        acc_next     = acc_reg;
        mode_next    = mode_reg;
        bcd_next     = bcd_reg;
        rd_byte      = 8'd0;
        load_req     = 1'b0;
        load_val     = 16'd0;

        // Tick: the residue follows elapsed mod reload and restarts on wrap.
        if (op_tick)
        begin
            elapsed_next = elapsed_inc;
            if ((elapsed_inc == '0) || (resid_inc == reload_reg))
                resid_next = 16'd0;
            else
                resid_next = resid_inc[15:0];
        end

        // Read: status first, then the latched count, then the live count.
        if (op_read)
        begin
            if (slf_reg)
            begin
                rd_byte  = status_reg;
                slf_next = 1'b0;
            end
            else if (clp_reg != PH_NONE)
            begin
                case (clp_reg)
                    PH_MSB:
                    begin
                        rd_byte  = latched_reg[15:8];
                        clp_next = PH_NONE;
                    end
                    PH_WLO:
                    begin
                        rd_byte  = latched_reg[7:0];
                        clp_next = PH_MSB;
                    end
                    default:
                    begin
                        rd_byte  = latched_reg[7:0];
                        clp_next = PH_NONE;
                    end
                endcase
            end
            else
            begin
                case (rph_reg)
                    PH_MSB: rd_byte = live[15:8];
                    PH_WHI:
                    begin
                        rd_byte  = live[15:8];
                        rph_next = PH_WLO;
                    end
                    PH_WLO:
                    begin
                        rd_byte  = live[7:0];
                        rph_next = PH_WHI;
                    end
                    default: rd_byte = live[7:0];
                endcase
            end
        end

        if (latch_req && (clp_reg == PH_NONE))
        begin
            latched_next = live;
            clp_next     = {1'b0, acc_reg};
        end
        // Status layout: output level in bit 7, bit 6 always zero.
        if (status_req)
        begin
            status_next = {level, 1'b0, acc_reg, mode_reg, bcd_reg};
            slf_next    = 1'b1;
        end
        if (program_req)
        begin
            acc_next  = cw_acc;
            rph_next  = {1'b0, cw_acc};
            wph_next  = {1'b0, cw_acc};
            mode_next = item.write_data[3:1];
            bcd_next  = item.write_data[0];
        end

        if (op_dwrite)
        begin
            case (wph_reg)
                PH_MSB:
                begin
                    load_req = 1'b1;
                    load_val = {item.write_data, 8'd0};
                end
                PH_WLO:
                begin
                    low_next = item.write_data;
                    wph_next = PH_WHI;
                end
                PH_WHI:
                begin
                    load_req = 1'b1;
                    load_val = {item.write_data, low_reg};
                    wph_next = PH_WLO;
                end
                default:
                begin
                    load_req = 1'b1;
                    load_val = {8'd0, item.write_data};
                end
            endcase
        end
        if (load_req)
        begin
            reload_next  = (load_val == 16'd0) ? FULL_RELOAD : {1'b0, load_val};
            elapsed_next = '0;
            resid_next   = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg  <= FULL_RELOAD;
            elapsed_reg <= '0;
            resid_reg   <= 16'd0;
            latched_reg <= 16'd0;
            clp_reg     <= PH_NONE;
            slf_reg     <= 1'b0;
            status_reg  <= 8'd0;
            rph_reg     <= PH_NONE;
            wph_reg     <= PH_NONE;
            low_reg     <= 8'd0;
            acc_reg     <= 2'd0;
            mode_reg    <= MODE_3;
            bcd_reg     <= 1'b0;
        end
        else
        begin
            reload_reg  <= reload_next;
            elapsed_reg <= elapsed_next;
            resid_reg   <= resid_next;
            latched_reg <= latched_next;
            clp_reg     <= clp_next;
            slf_reg     <= slf_next;
            status_reg  <= status_next;
            rph_reg     <= rph_next;
            wph_reg     <= wph_next;
            low_reg     <= low_next;
            acc_reg     <= acc_next;
            mode_reg    <= mode_next;
            bcd_reg     <= bcd_next;
        end
    end

endmodule
